[rtl/core/csfw_pkg.sv]
// ----------------------------------------------------------------------------
// csfw_pkg
// shared types, codes and defaults for the counting semaphore block
// ----------------------------------------------------------------------------
package csfw_pkg;

    localparam int unsigned MODE_W = 2;
    localparam int unsigned ID_W   = 6;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned ERR_W  = 2;
    localparam int unsigned CFG_W  = 5;

    // defaults for the top level parameters
    localparam int unsigned WAIT_DEPTH_DEF = 16;
    localparam int unsigned HOLD_SLOTS_DEF = 16;

    // caller numbers at or above this are reserved
    localparam int unsigned MAX_CALLERS = 64;

    // request codes
    localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RING_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TABLE_FULL = 2'd2;

    // count limits, two's complement
    localparam logic [CNT_W-1:0] COUNT_MAX = 6'b011111;
    localparam logic [CNT_W-1:0] COUNT_MIN = 6'b100000;

    localparam logic [CFG_W-1:0] RESET_COUNT = 5'd1;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;

    // result word, granted in bit 0
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [ERR_W-1:0] error;
        logic             is_holder;
        logic [ID_W-1:0]  woken_id;
        logic             woken_valid;
        logic             queued;
        logic             granted;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

    typedef struct packed {
        logic capture;   // take the request, register compares and ring read
        logic execute;   // apply the request and load the result
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;  // result register can take a new result
    } dp_status_t;

endpackage

[rtl/core/csfw_ram.sv]
// ----------------------------------------------------------------------------
// csfw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module csfw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/csfw_ctrl.sv]
// ----------------------------------------------------------------------------
// csfw_ctrl
// request sequencer: take one request, then apply it when the result is free
// ----------------------------------------------------------------------------
module csfw_ctrl
    import csfw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        cmd.capture = in_valid && (state_reg == S_IDLE);
        cmd.execute = (state_reg == S_EXEC) && status.out_free;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.execute)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/csfw_dp.sv]
// ----------------------------------------------------------------------------
// csfw_dp
// semaphore datapath: count, wait ring, holder table and result register
// ----------------------------------------------------------------------------
module csfw_dp
    import csfw_pkg::*;
#(
    parameter int unsigned WAIT_DEPTH = WAIT_DEPTH_DEF,
    parameter int unsigned HOLD_SLOTS = HOLD_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [MODE_W-1:0] in_mode,
    input  logic [ID_W-1:0]   in_id,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              out_ready,
    output logic              out_valid,
    output result_t           out_result
);

    localparam int unsigned PTR_W  = $clog2(WAIT_DEPTH);
    localparam int unsigned USED_W = $clog2(WAIT_DEPTH + 1);

    // request registers
    logic [MODE_W-1:0]     mode_reg;
    logic [ID_W-1:0]       id_reg;
    logic                  id_ok_reg;
    logic [HOLD_SLOTS-1:0] hit_vec_reg;
    logic [HOLD_SLOTS-1:0] free_vec_reg;

    // semaphore state
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [PTR_W-1:0]  head_reg,   head_next;
    logic [PTR_W-1:0]  tail_reg,   tail_next;
    logic [USED_W-1:0] used_reg,   used_next;
    logic [ID_W-1:0]   hold_reg  [HOLD_SLOTS];
    logic [ID_W-1:0]   hold_next [HOLD_SLOTS];

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;
    result_t res;

    // wait ring
    logic            ring_wr;
    logic [ID_W-1:0] ring_rd_data;

    // table update selects
    logic [HOLD_SLOTS-1:0] hit_oh;
    logic [HOLD_SLOTS-1:0] free_oh;
    logic [HOLD_SLOTS-1:0] free_rel;
    logic [HOLD_SLOTS-1:0] free_rel_oh;
    logic [HOLD_SLOTS-1:0] clr_oh;
    logic [HOLD_SLOTS-1:0] ins_oh;
    logic [ID_W-1:0]       ins_id;
    logic [CNT_W-1:0]      count_inc;
    logic                  count_le0;
    logic                  count_inc_le0;
    logic                  ring_full;

    csfw_ram #(
        .WIDTH (ID_W),
        .DEPTH (WAIT_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (tail_reg),
        .wr_data (id_reg),
        .rd_en   (cmd.capture),
        .rd_addr (head_reg),
        .rd_data (ring_rd_data)
    );

    // per slot compares, registered at capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= in_mode;
            id_reg    <= in_id;
            id_ok_reg <= (in_id != '0) && ({1'b0, in_id} < (ID_W + 1)'(MAX_CALLERS));
            for (int i = 0; i < HOLD_SLOTS; i++)
            begin
                hit_vec_reg[i]  <= (hold_reg[i] == in_id);
                free_vec_reg[i] <= (hold_reg[i] == '0);
            end
        end
    end

    always_comb
    begin
        // lowest set bit picks the first matching or free slot
        hit_oh      = hit_vec_reg & (~hit_vec_reg + HOLD_SLOTS'(1));
        free_oh     = free_vec_reg & (~free_vec_reg + HOLD_SLOTS'(1));
        free_rel    = free_vec_reg | hit_oh;
        free_rel_oh = free_rel & (~free_rel + HOLD_SLOTS'(1));

        count_le0     = count_reg[CNT_W-1] || (count_reg == '0);
        count_inc     = (count_reg == COUNT_MAX) ? count_reg : count_reg + CNT_W'(1);
        count_inc_le0 = count_inc[CNT_W-1] || (count_inc == '0);
        ring_full     = (used_reg == USED_W'(WAIT_DEPTH));

        res         = '0;
        count_next  = count_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        used_next   = used_reg;
        clr_oh      = '0;
        ins_oh      = '0;
        ins_id      = id_reg;
        ring_wr     = 1'b0;

        if (id_ok_reg)
        begin
            case (mode_reg)
                MODE_ACQUIRE:
                begin
                    if (count_le0)
                    begin
                        if (ring_full || (count_reg == COUNT_MIN))
                        begin
                            res.error = ERR_RING_FULL;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                            ring_wr    = cmd.execute;
                            tail_next  = (tail_reg == PTR_W'(WAIT_DEPTH - 1)) ? '0
                                                                              : tail_reg + PTR_W'(1);
                            used_next  = used_reg + USED_W'(1);
                            res.queued = 1'b1;
                        end
                    end
                    else
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        res.granted = 1'b1;
                        ins_oh      = free_oh;
                        if (free_vec_reg == '0)
                        begin
                            res.error = ERR_TABLE_FULL;
                        end
                    end
                end
                MODE_RELEASE:
                begin
                    count_next = count_inc;
                    clr_oh     = hit_oh;
                    if (count_inc_le0 && (used_reg != '0))
                    begin
                        head_next       = (head_reg == PTR_W'(WAIT_DEPTH - 1)) ? '0
                                                                               : head_reg + PTR_W'(1);
                        used_next       = used_reg - USED_W'(1);
                        res.woken_valid = 1'b1;
                        res.woken_id    = ring_rd_data;
                        ins_id          = ring_rd_data;
                        ins_oh          = free_rel_oh;
                        if (free_rel == '0)
                        begin
                            res.error = ERR_TABLE_FULL;
                        end
                    end
                end
                MODE_QUERY:
                begin
                    res.is_holder = |hit_vec_reg;
                end
                default:
                begin
                    res.is_holder = 1'b0;
                end
            endcase
        end
        res.count = count_next;

        // releasing slot is cleared before the woken caller is written
        for (int i = 0; i < HOLD_SLOTS; i++)
        begin
            hold_next[i] = hold_reg[i];
            if (clr_oh[i])
            begin
                hold_next[i] = '0;
            end
            if (ins_oh[i])
            begin
                hold_next[i] = ins_id;
            end
        end

        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= {1'b0, RESET_COUNT};
            head_reg      <= '0;
            tail_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HOLD_SLOTS; i++)
            begin
                hold_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                // re-initialize the whole semaphore
                count_reg <= {1'b0, cfg_wr_data};
                head_reg  <= '0;
                tail_reg  <= '0;
                used_reg  <= '0;
                for (int i = 0; i < HOLD_SLOTS; i++)
                begin
                    hold_reg[i] <= '0;
                end
            end
            else if (cmd.execute)
            begin
                count_reg <= count_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                used_reg  <= used_next;
                for (int i = 0; i < HOLD_SLOTS; i++)
                begin
                    hold_reg[i] <= hold_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            out_result_reg <= res;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_result      = out_result_reg;

endmodule

[rtl/core/counting_semaphore_fifo_waiters_unit.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_unit
// counting semaphore with a fifo ring of waiters and a table of holders
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request per transfer: tuser is the mode (acquire,
//   release, query), tdata the caller number. every request gives exactly
//   one result transfer on m_axis with the outcome and the new count.
//   cfg_wr_en / cfg_wr_data load a new initial count and empty the ring
//   and the holder table; write it only while no request is in flight.
// sequence
//   the accept cycle registers the per-slot holder compares and the ring
//   read at the head pointer; the apply cycle picks the first matching /
//   free slot, updates the state and loads the result register, waiting
//   while the result register is held. the next request is taken only
//   after the apply, so one request is in flight at a time.
// reset
//   count 1, ring and holder table empty at once, no clearing pass.
// backpressure
//   a held result does not block taking the next request; that request
//   waits in its apply cycle until the result register is free.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_unit
    import csfw_pkg::*;
#(
    parameter int unsigned WAIT_DEPTH = WAIT_DEPTH_DEF,
    parameter int unsigned HOLD_SLOTS = HOLD_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // request channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [5:0] caller_id, [7:6] zero
    input  logic [MODE_W-1:0]      s_axis_tuser,   // [1:0] mode
    // result channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] granted, [1] queued,
                                                   // [2] woken_valid, [8:3] woken_id,
                                                   // [9] is_holder, [11:10] error,
                                                   // [17:12] count, [23:18] zero
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data     // initial_count
);

    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    result;

    // sequencer: idle / apply
    csfw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // count, ring, holder table and result register
    csfw_dp #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .HOLD_SLOTS (HOLD_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_mode     (s_axis_tuser),
        .in_id       (s_axis_tdata[ID_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_result  (result)
    );

    // result word padded to whole bytes
    assign m_axis_tdata = {(OUT_TDATA_W - RESULT_W)'(0), result};

endmodule

[rtl/core/csfw_checker.sv]
// ----------------------------------------------------------------------------
// csfw_checker
// port level checks for the counting semaphore block
// ----------------------------------------------------------------------------
module csfw_checker
    import csfw_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    // a result is never both granted and queued
    a_grant_xor_queue: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("granted and queued together");

    // no woken caller without a wake
    a_woken_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[8:3] == '0)
        else $error("woken id without wake");

    // error code three is never produced
    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[11:10] != 2'b11)
        else $error("undefined error code");

endmodule

bind counting_semaphore_fifo_waiters_unit csfw_checker u_csfw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
